// ===== rtl/tlf_pkg.sv =====
`default_nettype none
package tlf_pkg;

   // line geometry
   localparam int LINE_WIDTH = 16;
   localparam int TAB_STOP   = 8;

   // column index and emit count widths
   localparam int IDX_W = $clog2(LINE_WIDTH);
   localparam int CNT_W = $clog2(LINE_WIDTH + 1);

   // character codes
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_NL    = 8'd10;
   localparam logic [7:0] CH_BLANK = 8'd32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_NEWL
   } tlf_state_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic       shift;
      logic       write;
      logic [7:0] wdata;
   } cell_ctrl_type;

   // end column (exclusive) of tab group g, clipped to the line
   function automatic int grp_end(input int g);
      int e;
      e = (g + 1) * TAB_STOP;
      return (e > LINE_WIDTH) ? LINE_WIDTH : e;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/tlf_if.sv =====
`default_nettype none
// input character channel
interface tlf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface

// emitted character channel
interface tlf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_out;
   logic       last;

   modport source (output valid, output char_out, output last, input ready);
   modport sink   (input valid, input char_out, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/tlf_cell.sv =====
`default_nettype none
module tlf_cell (
   input  wire                        clock,
   input  wire tlf_pkg::cell_ctrl_type ctrl,
   input  wire  [7:0]                 right_in,
   output logic [7:0]                 data_out
);
   import tlf_pkg::*;

   logic [7:0] data_ff;
   logic [7:0] data_in;

   // shift toward column 0 on emit, otherwise take a write
   always_comb begin
      data_in = data_ff;
      if (ctrl.shift) begin
         data_in = right_in;
      end else if (ctrl.write) begin
         data_in = ctrl.wdata;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule
`default_nettype wire

// ===== rtl/text_line_folder_unit.sv =====
`default_nettype none
// A character that completes no line is absorbed with no beat.
// A line of N buffered characters leaves as N+1 beats (newline last), one per cycle
// while rsp is ready; the column shift chain moves one column per beat. No input
// is taken while a line drains. Reset: sequencer idle, column and fold mark zero;
// cell contents are not cleared.
module text_line_folder_unit (
   input  wire      clock,
   input  wire      reset,
   tlf_req_if.sink  req_bus,
   tlf_rsp_if.source rsp_bus
);
   import tlf_pkg::*;

   tlf_state_type state_ff, state_in;
   logic [IDX_W-1:0] col_ff, col_in;
   logic [IDX_W-1:0] lb_ff, lb_in;     // last blank above column 0, 0 = none
   logic [CNT_W-1:0] cnt_ff, cnt_in;   // characters left to emit

   cell_ctrl_type    ctrl [LINE_WIDTH];
   logic [7:0]       cell_q [LINE_WIDTH];

   logic             accept;
   logic [CNT_W-1:0] col_ext;
   logic [CNT_W-1:0] tab_stop;
   logic [IDX_W-1:0] new_lb;
   logic [CNT_W-1:0] fold;
   logic             is_blank;

   // cell row: each cell takes its right neighbor on shift
   for (genvar i = 0; i < LINE_WIDTH; i++) begin : g_cell
      localparam int GRP_LO = (i / TAB_STOP) * TAB_STOP;
      logic [7:0] right_q;
      logic       tab_hit;

      if (i == LINE_WIDTH - 1) begin : g_end
         assign right_q = CH_BLANK;
      end else begin : g_mid
         assign right_q = cell_q[i+1];
      end

      // tab blanks this cell when it lies in the current group at or past the column
      assign tab_hit = (col_ff >= IDX_W'(GRP_LO)) && (col_ff <= IDX_W'(i));

      always_comb begin
         ctrl[i].shift = (state_ff == ST_EMIT) && rsp_bus.ready;
         ctrl[i].write = 1'b0;
         ctrl[i].wdata = req_bus.char_in;
         if (accept) begin
            if (req_bus.char_in == CH_TAB) begin
               ctrl[i].write = tab_hit;
               ctrl[i].wdata = CH_BLANK;
            end else if (req_bus.char_in != CH_NL) begin
               ctrl[i].write = (col_ff == IDX_W'(i));
            end
         end
      end

      tlf_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl[i]),
         .right_in (right_q),
         .data_out (cell_q[i])
      );
   end

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign col_ext       = CNT_W'(col_ff);
   assign is_blank      = (req_bus.char_in == CH_BLANK) && (col_ff != '0);

   // end of the tab group holding the current column
   always_comb begin
      tab_stop = CNT_W'(LINE_WIDTH);
      for (int g = 0; g < (LINE_WIDTH + TAB_STOP - 1) / TAB_STOP; g++) begin
         if ((col_ext >= CNT_W'(g * TAB_STOP)) && (col_ext < CNT_W'(grp_end(g)))) begin
            tab_stop = CNT_W'(grp_end(g));
         end
      end
   end

   // fold point once the last column is written
   assign new_lb = is_blank ? col_ff : lb_ff;
   assign fold   = (new_lb != '0) ? (CNT_W'(new_lb) + CNT_W'(1)) : CNT_W'(LINE_WIDTH);

   // sequencer
   always_comb begin
      state_in         = state_ff;
      col_in           = col_ff;
      lb_in            = lb_ff;
      cnt_in           = cnt_ff;
      rsp_bus.valid    = 1'b0;
      rsp_bus.char_out = cell_q[0];
      rsp_bus.last     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_bus.char_in)
                  CH_TAB: begin
                     if (tab_stop == CNT_W'(LINE_WIDTH)) begin
                        cnt_in   = CNT_W'(LINE_WIDTH);
                        col_in   = '0;
                        lb_in    = '0;
                        state_in = ST_EMIT;
                     end else begin
                        col_in = IDX_W'(tab_stop);
                        lb_in  = IDX_W'(tab_stop - CNT_W'(1));
                     end
                  end
                  CH_NL: begin
                     if (col_ff != '0) begin
                        cnt_in   = col_ext;
                        state_in = ST_EMIT;
                     end
                     col_in = '0;
                     lb_in  = '0;
                  end
                  default: begin
                     if (col_ff == IDX_W'(LINE_WIDTH - 1)) begin
                        cnt_in   = fold;
                        col_in   = IDX_W'(CNT_W'(LINE_WIDTH) - fold);
                        lb_in    = '0;
                        state_in = ST_EMIT;
                     end else begin
                        col_in = col_ff + IDX_W'(1);
                        lb_in  = new_lb;
                     end
                  end
               endcase
            end
         end
         ST_EMIT: begin
            rsp_bus.valid = 1'b1;
            if (rsp_bus.ready) begin
               cnt_in = cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = ST_NEWL;
               end
            end
         end
         ST_NEWL: begin
            rsp_bus.valid    = 1'b1;
            rsp_bus.char_out = CH_NL;
            rsp_bus.last     = 1'b1;
            if (rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= '0;
         lb_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         lb_ff    <= lb_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ===== verif/text_line_folder_checker.sv =====
`timescale 1ns / 100ps
// Watches both channels, folds each accepted input character into its own copy of
// the line buffer and compares every emitted beat with the oldest predicted one.
module text_line_folder_checker (
   input  wire clock,
   input  wire reset,
   tlf_req_if  req_mon,
   tlf_rsp_if  rsp_mon,
   output int  fail_count,
   output int  pending_count
);
   import tlf_pkg::*;

   typedef struct packed {
      logic [7:0] char_out;
      logic       last;
   } folded_beat_type;

   logic [7:0]      line_cells [LINE_WIDTH];
   int              line_col;
   folded_beat_type folded_beats [$];
   int              fails;

   initial begin
      fails         = 0;
      line_col      = 0;
      fail_count    = 0;
      pending_count = 0;
   end

   // queue columns 0..count-1, then the closing newline when count is nonzero
   task automatic emit_cells(input int count);
      folded_beat_type b;
      for (int i = 0; i < count; i++) begin
         b.char_out = line_cells[i];
         b.last     = 1'b0;
         folded_beats.push_back(b);
      end
      if (count > 0) begin
         b.char_out = CH_NL;
         b.last     = 1'b1;
         folded_beats.push_back(b);
      end
   endtask

   // one input character through the folding rules
   task automatic fold_char(input logic [7:0] ch);
      int pos;
      int p;
      int fold;
      int k;
      pos = line_col;
      if (pos >= LINE_WIDTH) pos = 0;
      if (ch == CH_TAB) begin
         // blanks up to the next tab stop, line flushed when full
         line_cells[pos] = CH_BLANK;
         pos++;
         while (pos < LINE_WIDTH && (pos % TAB_STOP) != 0) begin
            line_cells[pos] = CH_BLANK;
            pos++;
         end
         if (pos >= LINE_WIDTH) begin
            emit_cells(LINE_WIDTH);
            pos = 0;
         end
      end else if (ch == CH_NL) begin
         // empty lines produce nothing
         emit_cells(pos);
         pos = 0;
      end else begin
         line_cells[pos] = ch;
         pos++;
         if (pos >= LINE_WIDTH) begin
            // last blank above column 0 decides the fold point
            p = LINE_WIDTH - 1;
            while (p > 0 && line_cells[p] != CH_BLANK) p--;
            fold = (p > 0) ? p + 1 : LINE_WIDTH;
            emit_cells(fold);
            if (fold >= LINE_WIDTH) begin
               pos = 0;
            end else begin
               k = 0;
               for (int j = fold; j < LINE_WIDTH; j++) begin
                  line_cells[k] = line_cells[j];
                  k++;
               end
               pos = k;
            end
         end
      end
      line_col = pos;
   endtask

   // predict on input beats, compare on output beats
   always @(posedge clock) begin
      folded_beat_type want;
      if (reset) begin
         line_col = 0;
         folded_beats.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) fold_char(req_mon.char_in);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (folded_beats.size() == 0) begin
               $error("unexpected beat: char_out %0d last %0d", rsp_mon.char_out,
                      rsp_mon.last);
               fails++;
            end else begin
               want = folded_beats.pop_front();
               if (rsp_mon.char_out !== want.char_out) begin
                  $error("char_out mismatch: expected %0d actual %0d", want.char_out,
                         rsp_mon.char_out);
                  fails++;
               end
               if (rsp_mon.last !== want.last) begin
                  $error("last mismatch: expected %0d actual %0d", want.last,
                         rsp_mon.last);
                  fails++;
               end
            end
         end
      end
      fail_count    <= fails;
      pending_count <= folded_beats.size();
   end

endmodule

// ===== verif/text_line_folder_unit_tb.sv =====
`timescale 1ns / 100ps
module text_line_folder_unit_tb;
   import tlf_pkg::*;

   localparam int STALL_LIMIT = 3000;
   localparam int RANDOM_CHARS = 170;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   chars_sent;
   int   idle_cycles;
   bit   sender_steady;

   tlf_req_if req_bus ();
   tlf_rsp_if rsp_bus ();

   text_line_folder_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   text_line_folder_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   function automatic logic [7:0] word_char();
      return 8'($urandom_range(33, 126));
   endfunction

   // noise byte, biased toward the control codes
   function automatic logic [7:0] noise_char();
      case ($urandom_range(0, 7))
         0: return CH_TAB;
         1: return CH_NL;
         2: return CH_BLANK;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_char(input logic [7:0] ch);
      int gap;
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.char_in <= ch;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      chars_sent++;
   endtask

   // watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side back-pressure
   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         rsp_bus.ready <= 1'b1;
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(100, 300)) @(posedge clock);
         else repeat ($urandom_range(1, 12)) @(posedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // stimulus and verdict
   initial begin
      int n;
      req_bus.valid   <= 1'b0;
      req_bus.char_in <= 8'd0;
      chars_sent    = 0;
      idle_cycles   = 0;
      sender_steady = 1'b0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // newline at column 0 yields nothing
      send_char(CH_NL);
      // byte extremes then a plain newline
      send_char(8'h00);
      send_char(8'hFF);
      send_char(CH_NL);
      // two tabs fill the line
      send_char(CH_TAB);
      send_char(CH_TAB);
      // blank in the last column: whole line, no carry
      send_char(CH_TAB);
      repeat (7) send_char("b");
      send_char(CH_BLANK);
      // fold with carried-over word, then flush it
      send_char(CH_TAB);
      send_char("a");
      send_char("b");
      send_char("c");
      send_char(CH_BLANK);
      send_char("w");
      send_char("x");
      send_char("y");
      send_char("z");
      send_char(CH_NL);

      // random sequences, mostly text made of words
      while (chars_sent < RANDOM_CHARS) begin
         sender_steady = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               n = $urandom_range(1, 6);
               for (int w = 0; w < n; w++) begin
                  repeat ($urandom_range(1, 9)) send_char(word_char());
                  send_char(($urandom_range(0, 4) == 0) ? CH_TAB : CH_BLANK);
               end
               if ($urandom_range(0, 9) < 7) send_char(CH_NL);
            end
            5: begin
               // long word of up to 22 characters, often longer than the line
               repeat ($urandom_range(14, 22)) send_char(word_char());
            end
            6: begin
               // only blank sits at column 0
               send_char(CH_NL);
               send_char(CH_BLANK);
               repeat ($urandom_range(15, 17)) send_char(word_char());
            end
            7: begin
               repeat ($urandom_range(1, 3)) send_char(CH_NL);
            end
            default: begin
               repeat ($urandom_range(1, 8)) send_char(noise_char());
            end
         endcase
      end
      req_bus.valid <= 1'b0;

      // drain, then settle
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (pending_count != 0) $error("%0d expected beats never arrived", pending_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
